>>> src/group_reverse_stream_assert.svh
// assertion macros for the group reverse stream rtl
// depends on: clk and rst_n being declared in the module that uses them
`ifndef GROUP_REVERSE_STREAM_ASSERT_SVH
`define GROUP_REVERSE_STREAM_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled during reset
`define GRS_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("group_reverse_stream: same-cycle check failed");

// next-cycle implication, disabled during reset
`define GRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("group_reverse_stream: next-cycle check failed");

`else

`define GRS_ASSERT_IMPLIES(label, ante, cons)
`define GRS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/grs_pkg.sv
// shared types and constants for the group reverse stream block
// no dependencies
`timescale 1ns / 1ps

package grs_pkg;

    localparam int VALUE_W = 32;  // width of one list element
    localparam int CFG_W   = 7;   // width of the group_size register

    // controller to datapath
    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic rd_issue;  // launch one buffer read
    } grs_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit;        // the word being offered will start a burst
        logic rd_ok;       // a read may be launched this cycle
        logic issue_done;  // every read of the current burst is launched
    } grs_status_t;

endpackage

>>> src/grs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module grs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/grs_ctrl.sv
// controller: takes input words and sequences the drain of a burst
// depends on: grs_pkg
`timescale 1ns / 1ps

module grs_ctrl
    import grs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  grs_status_t status,
    output grs_cmd_t    cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg && status.emit)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (status.issue_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready     = ready_reg;
    assign cmd.accept   = s_tvalid && ready_reg;
    assign cmd.rd_issue = (state_reg == ST_DRAIN) && status.rd_ok;

endmodule

>>> src/grs_datapath.sv
// datapath: group buffer, fill and burst counters, output register
// depends on: grs_pkg, grs_ram, group_reverse_stream_assert.svh
`timescale 1ns / 1ps
`include "group_reverse_stream_assert.svh"

module grs_datapath
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [VALUE_W-1:0] in_value,
    input  logic               in_list_end,
    input  grs_cmd_t           cmd,
    output grs_status_t        status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] out_value,
    output logic               out_burst_last,
    output logic               out_list_end
);

    localparam int AW = $clog2(MAX_GROUP);
    localparam int CW = $clog2(MAX_GROUP + 1);

    logic [CFG_W-1:0]   group_size_reg;
    logic [CW-1:0]      fill_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      idx_reg;
    logic               reverse_reg;
    logic               end_reg;
    logic               pend_reg;
    logic               pend_last_reg;
    logic               pend_end_reg;
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_end_reg;

    logic [CW-1:0]      k_eff;
    logic [AW-1:0]      wr_addr;
    logic [CW-1:0]      n_new;
    logic               full_group;
    logic [CW-1:0]      rev_pos;
    logic [AW-1:0]      rd_addr;
    logic [VALUE_W-1:0] rd_data;
    logic               issue_last;

    // group size saturated into 1..MAX_GROUP
    always_comb
    begin
        priority if (group_size_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (group_size_reg > CFG_W'(MAX_GROUP))
        begin
            k_eff = CW'(MAX_GROUP);
        end
        else
        begin
            k_eff = CW'(group_size_reg);
        end
    end

    assign wr_addr    = (fill_reg >= CW'(MAX_GROUP)) ? AW'(MAX_GROUP - 1) : fill_reg[AW-1:0];
    assign n_new      = CW'(wr_addr) + CW'(1);
    assign full_group = (n_new >= k_eff);

    // newest first for a full group, oldest first for a short tail
    assign rev_pos    = n_reg - CW'(1) - idx_reg;
    assign rd_addr    = reverse_reg ? rev_pos[AW-1:0] : idx_reg[AW-1:0];
    assign issue_last = ((idx_reg + CW'(1)) == n_reg);

    grs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_GROUP)
    ) u_buffer (
        .clk     (clk),
        .wr_en   (cmd.accept),
        .wr_addr (wr_addr),
        .wr_data (in_value),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= CFG_W'(1);
            fill_reg       <= '0;
            n_reg          <= '0;
            idx_reg        <= '0;
            reverse_reg    <= 1'b0;
            end_reg        <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                group_size_reg <= cfg_data;
            end

            if (cmd.accept)
            begin
                if (full_group || in_list_end)
                begin
                    n_reg       <= n_new;
                    idx_reg     <= '0;
                    reverse_reg <= full_group;
                    end_reg     <= in_list_end;
                    fill_reg    <= '0;
                end
                else
                begin
                    fill_reg <= n_new;
                end
            end
            else if (cmd.rd_issue)
            begin
                idx_reg <= idx_reg + CW'(1);
            end

            pend_reg <= cmd.rd_issue;

            if (pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            pend_last_reg <= issue_last;
            pend_end_reg  <= issue_last && end_reg;
        end
        if (pend_reg)
        begin
            out_value_reg <= rd_data;
            out_last_reg  <= pend_last_reg;
            out_end_reg   <= pend_end_reg;
        end
    end

    assign status.emit       = full_group || in_list_end;
    assign status.issue_done = (idx_reg == n_reg);
    assign status.rd_ok      = (idx_reg != n_reg) && !pend_reg && (!out_valid_reg || out_ready);

    assign out_valid      = out_valid_reg;
    assign out_value      = out_value_reg;
    assign out_burst_last = out_last_reg;
    assign out_list_end   = out_end_reg;

    `GRS_ASSERT_IMPLIES(a_fill_below_max, 1'b1, fill_reg < CW'(MAX_GROUP))
    `GRS_ASSERT_IMPLIES(a_read_in_burst, cmd.rd_issue, idx_reg < n_reg)
    `GRS_ASSERT_NEXT(a_read_lands, pend_reg, out_valid_reg)
    `GRS_ASSERT_IMPLIES(a_no_accept_mid_burst, cmd.accept, idx_reg == n_reg && !pend_reg)

endmodule

>>> src/group_reverse_stream.sv
// top level of the group reverse stream block
// depends on: grs_pkg, grs_ctrl, grs_datapath, grs_ram
//
// usage
//   s_* carries list words in: s_tdata is the element value, s_tlast marks the
//   final element of the list. m_* carries the reordered words out: m_tdata is
//   the value, m_tlast marks the last word of a burst, m_tuser marks the final
//   word of the whole list. cfg_valid/cfg_data write group_size (always ready);
//   write it only while the block is idle. zero acts as 1, above MAX_GROUP
//   acts as MAX_GROUP.
//   words are buffered until group_size are held, then sent newest first; a
//   short tail at the end mark goes out oldest first.
// timing
//   a word that completes no burst is taken without dropping s_tready. a word
//   that starts a burst of n words holds s_tready low until every read of the
//   burst is launched: a read is not launched while an earlier one is still
//   pending (registered ram read, then the output register).
// reset and stall
//   reset empties the buffer count, sets group_size to 1 and drops all valids;
//   buffer contents are not cleared. when m_tready is low the output word holds
//   and no further read is launched until it is taken.
`timescale 1ns / 1ps

module group_reverse_stream
    import grs_pkg::*;
#(
    parameter int MAX_GROUP = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,   // group_size
    // input words
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,    // [31:0] value
    input  logic               s_tlast,    // list_end
    // output words
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [VALUE_W-1:0] m_tdata,    // [31:0] out_value
    output logic               m_tlast,    // burst_last
    output logic               m_tuser     // [0] out_list_end
);

    grs_cmd_t    cmd;
    grs_status_t status;

    // the register takes every write at once
    assign cfg_ready = 1'b1;

    grs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    grs_datapath #(
        .MAX_GROUP (MAX_GROUP)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .in_value       (s_tdata),
        .in_list_end    (s_tlast),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_value      (m_tdata),
        .out_burst_last (m_tlast),
        .out_list_end   (m_tuser)
    );

endmodule
